[design/b2bcd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2bcd_pkg: shared types and helpers for the binary to packed BCD converter
// Digit width, output field layout and the per-digit add-3 correction.
// ----------------------------------------------------------------------------
`default_nettype none

package b2bcd_pkg;

  localparam int DIGIT_W    = 4;
  localparam int MAX_DIGITS = 20;
  localparam int OUT_W      = MAX_DIGITS * DIGIT_W;  // 80-bit digit image
  localparam int LOW_W      = 64;                    // digits 0..15
  localparam int HIGH_W     = 13;                    // digits 16..19, top digit is 1 bit

  typedef struct packed {
    logic [LOW_W-1:0]  low;
    logic [HIGH_W-1:0] high;
  } result_t;

  // double-dabble correction: digits of 5 and up get 3 added before the shift
  function automatic logic [DIGIT_W-1:0] dabble_fix(input logic [DIGIT_W-1:0] d);
    dabble_fix = (d >= 4'd5) ? d + 4'd3 : d;
  endfunction

  // true when every packed digit is a legal decimal digit
  function automatic logic digits_ok(input logic [OUT_W-1:0] v);
    logic ok;
    ok = 1'b1;
    for (int k = 0; k < MAX_DIGITS; k++) begin
      if (v[k*DIGIT_W +: DIGIT_W] > 4'd9) ok = 1'b0;
    end
    digits_ok = ok;
  endfunction

endpackage

`default_nettype wire

[design/b2bcd_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2bcd_cell: one shift-add-3 step
// Corrects every digit, shifts the next binary bit into the digit string,
// and registers the result for the following cell.
// ----------------------------------------------------------------------------
`default_nettype none

module b2bcd_cell #(
  parameter int DIGITS = 20,
  parameter int BITS   = 64
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  en,
  input  wire logic                                  in_valid,
  input  wire logic [DIGITS*b2bcd_pkg::DIGIT_W-1:0]  in_bcd,
  input  wire logic [BITS-1:0]                       in_bin,
  output logic                                       out_valid,
  output logic [DIGITS*b2bcd_pkg::DIGIT_W-1:0]       out_bcd,
  output logic [BITS-1:0]                            out_bin
);

  localparam int DW    = b2bcd_pkg::DIGIT_W;
  localparam int BCD_W = DIGITS * DW;

  logic [BCD_W-1:0] fixed;

  always_comb begin
    for (int d = 0; d < DIGITS; d++) begin
      fixed[d*DW +: DW] = b2bcd_pkg::dabble_fix(in_bcd[d*DW +: DW]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // top bit of the top digit falls off: result stays modulo 10^DIGITS
  always_ff @(posedge clk) begin
    if (en) begin
      out_bcd <= {fixed[BCD_W-2:0], in_bin[BITS-1]};
      out_bin <= {in_bin[BITS-2:0], 1'b0};
    end
  end

endmodule

`default_nettype wire

[design/b2bcd_outbuf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2bcd_outbuf: output register with skid entry
// Catches the transaction leaving the cell chain when the consumer stalls;
// a full skid entry freezes the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module b2bcd_outbuf (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire b2bcd_pkg::result_t  in_data,
  output logic                     hold,
  output logic                     out_valid,
  output b2bcd_pkg::result_t       out_data,
  input  wire logic                out_stall
);

  logic               skid_valid;
  b2bcd_pkg::result_t skid_data;
  logic               take;
  logic               push;

  assign take = out_valid && !out_stall;
  assign push = in_valid && !skid_valid;
  assign hold = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) skid_valid <= 1'b0;
    end else if (push) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) out_data <= skid_data;
    end else if (push) begin
      if (!out_valid || take) begin
        out_data <= in_data;
      end else begin
        skid_data <= in_data;
      end
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry full while output register empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && take) |=> (out_valid && !skid_valid && out_data == $past(skid_data)))
    else $error("skid entry did not move into output register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && !skid_valid && push) |=> (skid_valid && $stable(out_data)))
    else $error("stalled output overwritten instead of filling skid entry");

endmodule

`default_nettype wire

[design/binary_to_packed_bcd_64_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_packed_bcd_64_top: 64-bit binary to packed BCD converter
// Pipelined double-dabble: a chain of shift-add-3 cells, one per input bit,
// followed by an output register with a skid entry.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                 payload
//  --------  ---  ------------------------  -----------------------------------
//  binary    in   binary_valid/binary_stall binary_value[63:0]
//  bcd       out  bcd_valid/bcd_stall       bcd_low_digits[63:0], bcd_high_digits[12:0]
//
//  One transaction per cycle sustained while bcd_stall is low. Each cell in the
//  chain registers its step, and the output register follows the chain.
//  Reset (rst, synchronous) clears the valid flag of every cell and of the
//  output buffer; digit and binary payload registers are not reset.
//  A stalled output fills the skid entry; while it is full the whole chain
//  freezes and binary_stall is high (driven straight from a register).
//
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_packed_bcd_64_top #(
  parameter int INPUT_BITS = 64,
  parameter int BCD_DIGITS = 20
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        binary_valid,
  output logic             binary_stall,
  input  wire logic [63:0] binary_value,
  // output channel
  output logic             bcd_valid,
  input  wire logic        bcd_stall,
  output logic [63:0]      bcd_low_digits,
  output logic [12:0]      bcd_high_digits
);

  localparam int DW    = b2bcd_pkg::DIGIT_W;
  localparam int BCD_W = BCD_DIGITS * DW;

  // stage k holds the state after k input bits have been shifted in
  logic             stage_valid [0:INPUT_BITS];
  logic [BCD_W-1:0] stage_bcd   [0:INPUT_BITS];
  logic [INPUT_BITS-1:0] stage_bin [0:INPUT_BITS];

  logic                       hold;       // skid entry full: chain frozen
  logic [b2bcd_pkg::OUT_W-1:0] bcd_wide;
  b2bcd_pkg::result_t         chain_result;
  b2bcd_pkg::result_t         out_result;

  // chain head: digits start at zero, bits above INPUT_BITS are dropped
  assign stage_valid[0] = binary_valid;
  assign stage_bcd[0]   = '0;
  assign stage_bin[0]   = binary_value[INPUT_BITS-1:0];

  for (genvar k = 0; k < INPUT_BITS; k++) begin : g_cell
    b2bcd_cell #(
      .DIGITS (BCD_DIGITS),
      .BITS   (INPUT_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (!hold),
      .in_valid  (stage_valid[k]),
      .in_bcd    (stage_bcd[k]),
      .in_bin    (stage_bin[k]),
      .out_valid (stage_valid[k+1]),
      .out_bcd   (stage_bcd[k+1]),
      .out_bin   (stage_bin[k+1])
    );
  end

  // widen to the full 20-digit image; unbuilt digits read as zero
  always_comb begin
    bcd_wide = '0;
    bcd_wide[BCD_W-1:0] = stage_bcd[INPUT_BITS];
  end

  assign chain_result.low  = bcd_wide[b2bcd_pkg::LOW_W-1:0];
  assign chain_result.high = bcd_wide[b2bcd_pkg::LOW_W +: b2bcd_pkg::HIGH_W];

  b2bcd_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stage_valid[INPUT_BITS]),
    .in_data   (chain_result),
    .hold      (hold),
    .out_valid (bcd_valid),
    .out_data  (out_result),
    .out_stall (bcd_stall)
  );

  assign binary_stall    = hold;
  assign bcd_low_digits  = out_result.low;
  assign bcd_high_digits = out_result.high;

  // a frozen chain must keep its final stage intact
  a_chain_frozen: assert property (@(posedge clk) disable iff (rst)
    (hold && !$past(rst)) |=> (stage_valid[INPUT_BITS] == $past(stage_valid[INPUT_BITS])
                               && stage_bcd[INPUT_BITS] == $past(stage_bcd[INPUT_BITS])))
    else $error("cell chain moved while skid entry full");

  // last cell: remaining binary bits are all consumed
  a_bits_consumed: assert property (@(posedge clk) disable iff (rst)
    stage_valid[INPUT_BITS] |-> (stage_bin[INPUT_BITS] == '0))
    else $error("binary bits left over at end of cell chain");

  // every delivered digit is a decimal digit
  a_digits_legal: assert property (@(posedge clk) disable iff (rst)
    bcd_valid |-> b2bcd_pkg::digits_ok({3'b000, bcd_high_digits, bcd_low_digits}))
    else $error("output digit out of decimal range");

endmodule

`default_nettype wire
